// ===== design/mtp_pkg.sv =====
`timescale 1ns / 1ps

package mtp_pkg;

   localparam int VLQ_MAX_BYTES_DEFAULT = 4;
   localparam int QUEUE_DEPTH_DEFAULT   = 2;

   localparam logic [7:0] HI_NIBBLE     = 8'hF0;
   localparam logic [7:0] LO_NIBBLE     = 8'h0F;
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_BEND   = 8'hE0;
   localparam logic [7:0] STATUS_PROG   = 8'hC0;
   localparam logic [7:0] STATUS_PRESS  = 8'hD0;
   localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
   localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
   localparam logic [7:0] STATUS_META   = 8'hFF;
   localparam logic [7:0] META_TEMPO    = 8'h51;
   localparam logic [7:0] META_EOT      = 8'h2F;
   localparam logic [27:0] TEMPO_LENGTH = 28'd3;

   typedef enum logic [3:0] {
      PH_DELTA,
      PH_STATUS,
      PH_P1,
      PH_P2,
      PH_SXLEN,
      PH_MTYPE,
      PH_MLEN,
      PH_SKIP,
      PH_TEMPO
   } mtp_phase_type;

   typedef enum logic [1:0] {
      ITEM_DATA,
      ITEM_LAST,
      ITEM_RESTART
   } mtp_item_kind_type;

   typedef struct packed {
      mtp_item_kind_type kind;
      logic [7:0]        data_byte;
   } mtp_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [27:0] delta_ticks;
      logic [7:0]  status_class;
      logic [3:0]  channel;
      logic [7:0]  param_one;
      logic [7:0]  param_two;
      logic [7:0]  meta_kind;
      logic [27:0] payload_length;
      logic [23:0] tempo;
      logic        tempo_valid;
      logic        track_done;
   } mtp_result_type;

   function automatic logic is_channel(input logic [7:0] status);
      logic [7:0] hi;
      hi = status & HI_NIBBLE;
      return (hi >= STATUS_NOTE_OFF) && (hi <= STATUS_BEND);
   endfunction

   function automatic logic two_params(input logic [7:0] status);
      logic [7:0] hi;
      hi = status & HI_NIBBLE;
      return (hi != STATUS_PROG) && (hi != STATUS_PRESS);
   endfunction

   function automatic logic known_status(input logic [7:0] status);
      return is_channel(status) || status == STATUS_SYSEX || status == STATUS_ESCAPE ||
             status == STATUS_META;
   endfunction

   // phase that the first body byte of an event with this status goes to
   function automatic mtp_phase_type body_phase(input logic [7:0] status);
      mtp_phase_type ph;
      if (is_channel(status)) begin
         ph = PH_P1;
      end else if (status == STATUS_META) begin
         ph = PH_MTYPE;
      end else if (status == STATUS_SYSEX || status == STATUS_ESCAPE) begin
         ph = PH_SXLEN;
      end else begin
         ph = PH_DELTA;
      end
      return ph;
   endfunction

endpackage

// ===== design/mtp_front.sv =====
`timescale 1ns / 1ps

module mtp_front
   import mtp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_op,
   input  logic [7:0]   req_data_byte,
   input  logic         req_last_byte,
   input  logic         pop,
   output logic         head_valid,
   output mtp_item_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   mtp_item_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   mtp_item_type  incoming;
   logic          push;

   always_comb begin
      if (req_op) begin
         incoming.kind = ITEM_RESTART;
      end else if (req_last_byte) begin
         incoming.kind = ITEM_LAST;
      end else begin
         incoming.kind = ITEM_DATA;
      end
      incoming.data_byte = req_data_byte;
   end

   assign req_stall  = (count_ff == FULL_COUNT);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && head_valid) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !(pop && head_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop && head_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ===== design/mtp_parser.sv =====
`timescale 1ns / 1ps

module mtp_parser
   import mtp_pkg::*;
#(
   parameter int VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  mtp_item_type   head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output mtp_result_type rsp
);

   mtp_phase_type  phase_ff, phase_in;
   logic [27:0]    vlq_acc_ff, vlq_acc_in;
   logic [2:0]     vlq_cnt_ff, vlq_cnt_in;
   logic [7:0]     running_ff, running_in;
   logic [7:0]     current_ff, current_in;
   logic [27:0]    held_delta_ff, held_delta_in;
   logic [7:0]     held_param_ff, held_param_in;
   logic [7:0]     held_meta_ff, held_meta_in;
   logic [27:0]    skip_ff, skip_in;
   logic [23:0]    tempo_acc_ff, tempo_acc_in;
   logic [1:0]     tempo_cnt_ff, tempo_cnt_in;
   logic           halted_ff, halted_in;
   logic           rsp_valid_ff, rsp_valid_in;
   mtp_result_type rsp_ff, rsp_in;

   logic [7:0]     b;
   logic [2:0]     cnt_new;
   logic [27:0]    acc_new;
   logic           vlq_done, vlq_long;
   mtp_phase_type  work_phase;
   logic [7:0]     work_status;
   logic           ev_chan, ev_long, tempo_ok, err;
   logic [7:0]     p2;
   logic [27:0]    long_len;
   logic           produce, advance, active;

   assign b        = head.data_byte;
   assign cnt_new  = vlq_cnt_ff + 3'd1;
   assign acc_new  = {vlq_acc_ff[20:0], b[6:0]};
   assign vlq_done = !b[7];
   assign vlq_long = b[7] && (cnt_new >= 3'(VLQ_MAX_BYTES));

   // a result slot must be free (or draining) before any item is consumed
   assign advance = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop     = advance;
   assign active  = advance && head.kind != ITEM_RESTART && !halted_ff;

   always_comb begin
      phase_in      = phase_ff;
      vlq_acc_in    = vlq_acc_ff;
      vlq_cnt_in    = vlq_cnt_ff;
      running_in    = running_ff;
      current_in    = current_ff;
      held_delta_in = held_delta_ff;
      held_param_in = held_param_ff;
      held_meta_in  = held_meta_ff;
      skip_in       = skip_ff;
      tempo_acc_in  = tempo_acc_ff;
      tempo_cnt_in  = tempo_cnt_ff;
      halted_in     = halted_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ev_chan       = 1'b0;
      ev_long       = 1'b0;
      tempo_ok      = 1'b0;
      err           = 1'b0;
      p2            = '0;
      long_len      = vlq_acc_ff;
      produce       = 1'b0;

      // running status: data byte in status position is re-taken as body byte
      work_phase  = phase_ff;
      work_status = current_ff;
      if (phase_ff == PH_STATUS && !b[7]) begin
         work_status = running_ff;
         current_in  = running_ff;
         if (known_status(running_ff)) begin
            work_phase = body_phase(running_ff);
         end else begin
            err = 1'b1;
         end
      end

      if (!err) begin
         unique case (work_phase)
            PH_DELTA: begin
               vlq_cnt_in = cnt_new;
               vlq_acc_in = acc_new;
               if (vlq_done) begin
                  held_delta_in = acc_new;
                  vlq_acc_in    = '0;
                  vlq_cnt_in    = '0;
                  phase_in      = PH_STATUS;
               end else if (vlq_long) begin
                  err = 1'b1;
               end
            end
            PH_STATUS: begin
               running_in = b;
               current_in = b;
               vlq_acc_in = '0;
               vlq_cnt_in = '0;
               if (known_status(b)) begin
                  phase_in = body_phase(b);
               end else begin
                  err = 1'b1;
               end
            end
            PH_P1: begin
               held_param_in = b;
               if (two_params(work_status)) begin
                  phase_in = PH_P2;
               end else begin
                  ev_chan = 1'b1;
               end
            end
            PH_P2: begin
               ev_chan = 1'b1;
               p2      = b;
            end
            PH_MTYPE: begin
               held_meta_in = b;
               vlq_acc_in   = '0;
               vlq_cnt_in   = '0;
               phase_in     = PH_MLEN;
            end
            PH_SXLEN, PH_MLEN: begin
               vlq_cnt_in = cnt_new;
               vlq_acc_in = acc_new;
               if (vlq_done) begin
                  if (work_phase == PH_MLEN && held_meta_ff == META_TEMPO &&
                      acc_new == TEMPO_LENGTH) begin
                     tempo_acc_in = '0;
                     tempo_cnt_in = '0;
                     phase_in     = PH_TEMPO;
                  end else if (acc_new != '0) begin
                     skip_in  = acc_new;
                     phase_in = PH_SKIP;
                  end else begin
                     ev_long  = 1'b1;
                     long_len = acc_new;
                  end
               end else if (vlq_long) begin
                  err = 1'b1;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 28'd1;
               if (skip_ff == 28'd1) begin
                  ev_long = 1'b1;
               end
            end
            PH_TEMPO: begin
               tempo_acc_in = {tempo_acc_ff[15:0], b};
               if (tempo_cnt_ff >= 2'd2) begin
                  ev_long  = 1'b1;
                  tempo_ok = 1'b1;
               end else begin
                  tempo_cnt_in = tempo_cnt_ff + 2'd1;
               end
            end
            default: err = 1'b1;
         endcase
      end

      if (ev_chan || ev_long) begin
         phase_in   = PH_DELTA;
         vlq_acc_in = '0;
         vlq_cnt_in = '0;
      end

      if (advance) begin
         rsp_in = '0;
         if (active) begin
            if (ev_chan) begin
               produce              = 1'b1;
               rsp_in.delta_ticks   = held_delta_ff;
               rsp_in.status_class  = work_status & HI_NIBBLE;
               rsp_in.channel       = work_status[3:0] & LO_NIBBLE[3:0];
               rsp_in.param_one     = (work_phase == PH_P1) ? b : held_param_ff;
               rsp_in.param_two     = p2;
            end else if (ev_long) begin
               produce               = 1'b1;
               rsp_in.delta_ticks    = held_delta_ff;
               rsp_in.status_class   = current_ff;
               rsp_in.payload_length = long_len;
               if (current_ff == STATUS_META) begin
                  rsp_in.meta_kind = held_meta_ff;
                  if (tempo_ok) begin
                     rsp_in.tempo       = tempo_acc_in;
                     rsp_in.tempo_valid = 1'b1;
                  end
                  if (held_meta_ff == META_EOT) begin
                     rsp_in.track_done = 1'b1;
                     halted_in         = 1'b1;
                  end
               end
            end else if (err || head.kind == ITEM_LAST) begin
               produce            = 1'b1;
               rsp_in.result_kind = 1'b1;
            end
            if (produce && (err || head.kind == ITEM_LAST)) begin
               halted_in = 1'b1;
            end
            // a byte in the last item that gets no event is still an error
            if (err && (ev_chan || ev_long)) begin
               halted_in = 1'b1;
            end
         end else begin
            rsp_in = rsp_ff;
         end
         if (produce) begin
            rsp_valid_in = 1'b1;
         end
      end

      if (!active) begin
         phase_in      = phase_ff;
         vlq_acc_in    = vlq_acc_ff;
         vlq_cnt_in    = vlq_cnt_ff;
         running_in    = running_ff;
         current_in    = current_ff;
         held_delta_in = held_delta_ff;
         held_param_in = held_param_ff;
         held_meta_in  = held_meta_ff;
         skip_in       = skip_ff;
         tempo_acc_in  = tempo_acc_ff;
         tempo_cnt_in  = tempo_cnt_ff;
      end

      if (advance && head.kind == ITEM_RESTART) begin
         phase_in      = PH_DELTA;
         vlq_acc_in    = '0;
         vlq_cnt_in    = '0;
         running_in    = '0;
         current_in    = '0;
         held_delta_in = '0;
         held_param_in = '0;
         held_meta_in  = '0;
         skip_in       = '0;
         tempo_acc_in  = '0;
         tempo_cnt_in  = '0;
         halted_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DELTA;
         vlq_acc_ff    <= '0;
         vlq_cnt_ff    <= '0;
         running_ff    <= '0;
         current_ff    <= '0;
         held_delta_ff <= '0;
         held_param_ff <= '0;
         held_meta_ff  <= '0;
         skip_ff       <= '0;
         tempo_acc_ff  <= '0;
         tempo_cnt_ff  <= '0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         vlq_acc_ff    <= vlq_acc_in;
         vlq_cnt_ff    <= vlq_cnt_in;
         running_ff    <= running_in;
         current_ff    <= current_in;
         held_delta_ff <= held_delta_in;
         held_param_ff <= held_param_in;
         held_meta_ff  <= held_meta_in;
         skip_ff       <= skip_in;
         tempo_acc_ff  <= tempo_acc_in;
         tempo_cnt_ff  <= tempo_cnt_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && halted_ff && head.kind != ITEM_RESTART) |=> !$rose(rsp_valid_ff))
      else $error("halted parser produced a result");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.result_kind) |->
         (rsp_ff.delta_ticks == '0 && rsp_ff.status_class == '0 && !rsp_ff.tempo_valid &&
          !rsp_ff.track_done && rsp_ff.payload_length == '0))
      else $error("error result carries event fields");

   a_tempo_meta: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tempo_valid) |->
         (rsp_ff.status_class == STATUS_META && rsp_ff.meta_kind == META_TEMPO))
      else $error("tempo outside a set-tempo meta event");

   a_eot_halts: assert property (@(posedge clock) disable iff (reset)
      (advance && produce && rsp_in.track_done) |=> halted_ff)
      else $error("end of track did not halt the parser");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed");

endmodule

// ===== design/midi_track_event_parser_core.sv =====
`timescale 1ns / 1ps

// Track event parser for one MIDI track chunk.
// Request channel (req_*): one item per cycle while req_stall is low,
// either a track byte (req_op = 0, req_last_byte marks the final byte) or a
// restart (req_op = 1) that clears parser state and running status. Items go
// into a short queue; the parser pulls one per cycle while no result stalls.
// Response channel (rsp_*): one item per complete channel, sysex or meta
// event, or an error item (rsp_result_kind = 1) after which the parser
// ignores bytes until a restart. End of track also halts it.
// A byte accepted into the queue is parsed from the queue head; its result
// is registered. Sustained rate is one byte per cycle while rsp_stall is
// low, set by the parser step with its output register.
// When the receiver stalls, the result register holds and the parser waits;
// the queue keeps taking bytes until it is full, then req_stall rises.
// Reset clears the queue, the parser state and any pending result.

module midi_track_event_parser_core
   import mtp_pkg::*;
#(
   parameter int VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [27:0] rsp_delta_ticks,
   output logic [7:0]  rsp_status_class,
   output logic [3:0]  rsp_channel,
   output logic [7:0]  rsp_param_one,
   output logic [7:0]  rsp_param_two,
   output logic [7:0]  rsp_meta_kind,
   output logic [27:0] rsp_payload_length,
   output logic [23:0] rsp_tempo,
   output logic        rsp_tempo_valid,
   output logic        rsp_track_done
);

   logic           head_valid;
   mtp_item_type   head;
   logic           pop;
   mtp_result_type rsp;

   mtp_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .pop           (pop),
      .head_valid    (head_valid),
      .head          (head)
   );

   mtp_parser #(
      .VLQ_MAX_BYTES(VLQ_MAX_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_result_kind    = rsp.result_kind;
   assign rsp_delta_ticks    = rsp.delta_ticks;
   assign rsp_status_class   = rsp.status_class;
   assign rsp_channel        = rsp.channel;
   assign rsp_param_one      = rsp.param_one;
   assign rsp_param_two      = rsp.param_two;
   assign rsp_meta_kind      = rsp.meta_kind;
   assign rsp_payload_length = rsp.payload_length;
   assign rsp_tempo          = rsp.tempo;
   assign rsp_tempo_valid    = rsp.tempo_valid;
   assign rsp_track_done     = rsp.track_done;

endmodule

// ===== bench/midi_track_event_parser_core_test.sv =====
`timescale 1ns / 1ps

module midi_track_event_parser_core_test
   import mtp_pkg::*;
();

   localparam int   VLQ_LIMIT      = VLQ_MAX_BYTES_DEFAULT;
   localparam int   WATCHDOG_LIMIT = 5000;
   localparam int   MAX_PRINTS     = 200;
   localparam int   ITEMS_PER_MIX  = 150;
   localparam logic OP_BYTE        = 1'b0;
   localparam logic OP_RESTART     = 1'b1;
   localparam logic KIND_ERROR     = 1'b1;

   typedef enum int {VLQ_MORE, VLQ_DONE, VLQ_LONG} vlq_status_type;
   typedef enum int {PARSE_NONE, PARSE_EVENT, PARSE_ERROR} parse_status_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_result_kind;
   logic [27:0] rsp_delta_ticks;
   logic [7:0]  rsp_status_class;
   logic [3:0]  rsp_channel;
   logic [7:0]  rsp_param_one;
   logic [7:0]  rsp_param_two;
   logic [7:0]  rsp_meta_kind;
   logic [27:0] rsp_payload_length;
   logic [23:0] rsp_tempo;
   logic        rsp_tempo_valid;
   logic        rsp_track_done;

   midi_track_event_parser_core #(.VLQ_MAX_BYTES(VLQ_LIMIT)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_delta_ticks    (rsp_delta_ticks),
      .rsp_status_class   (rsp_status_class),
      .rsp_channel        (rsp_channel),
      .rsp_param_one      (rsp_param_one),
      .rsp_param_two      (rsp_param_two),
      .rsp_meta_kind      (rsp_meta_kind),
      .rsp_payload_length (rsp_payload_length),
      .rsp_tempo          (rsp_tempo),
      .rsp_tempo_valid    (rsp_tempo_valid),
      .rsp_track_done     (rsp_track_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state as the predictor sees it
   mtp_phase_type trk_phase;
   logic [27:0]   vlq_value;
   logic [2:0]    vlq_len;
   logic [7:0]    stored_status;
   logic [7:0]    event_status;
   logic [27:0]   event_delta;
   logic [7:0]    first_param;
   logic [7:0]    meta_type;
   logic [27:0]   bytes_to_skip;
   logic [23:0]   tempo_value;
   logic [1:0]    tempo_len;
   logic          parser_halted;

   mtp_result_type pending_events[$];
   logic [7:0]     track_bytes[$];
   logic [7:0]     stream_status;
   int             mismatches;
   int             live_items;
   int             idle_cycles;
   int             send_idle_pct;
   int             recv_stall_pct;

   function automatic void clear_parser();
      trk_phase     = PH_DELTA;
      vlq_value     = '0;
      vlq_len       = '0;
      stored_status = '0;
      event_status  = '0;
      event_delta   = '0;
      first_param   = '0;
      meta_type     = '0;
      bytes_to_skip = '0;
      tempo_value   = '0;
      tempo_len     = '0;
      parser_halted = 1'b0;
   endfunction

   function automatic vlq_status_type take_vlq_byte(input logic [7:0] b);
      vlq_len   = vlq_len + 3'd1;
      vlq_value = {vlq_value[20:0], b[6:0]};
      if (!b[7]) return VLQ_DONE;
      if (vlq_len >= VLQ_LIMIT) return VLQ_LONG;
      return VLQ_MORE;
   endfunction

   // returns 0 when the status is not one the parser knows
   function automatic logic start_body(input logic [7:0] s);
      logic [7:0] hi;
      hi = s & HI_NIBBLE;
      event_status = s;
      vlq_value = '0;
      vlq_len = '0;
      if (hi >= STATUS_NOTE_OFF && hi <= STATUS_BEND) begin
         trk_phase = PH_P1;
      end else if (s == STATUS_SYSEX || s == STATUS_ESCAPE) begin
         trk_phase = PH_SXLEN;
      end else if (s == STATUS_META) begin
         trk_phase = PH_MTYPE;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic mtp_result_type long_event(input logic with_tempo);
      mtp_result_type ev;
      ev = '0;
      ev.delta_ticks = event_delta;
      ev.status_class = event_status;
      ev.payload_length = vlq_value;
      if (event_status == STATUS_META) begin
         ev.meta_kind = meta_type;
         if (with_tempo) begin
            ev.tempo = tempo_value;
            ev.tempo_valid = 1'b1;
         end
         if (meta_type == META_EOT) begin
            ev.track_done = 1'b1;
            parser_halted = 1'b1;
         end
      end
      trk_phase = PH_DELTA;
      vlq_value = '0;
      vlq_len = '0;
      return ev;
   endfunction

   function automatic mtp_result_type channel_event(input logic [7:0] p2);
      mtp_result_type ev;
      ev = '0;
      ev.delta_ticks = event_delta;
      ev.status_class = event_status & HI_NIBBLE;
      ev.channel = event_status[3:0];
      ev.param_one = first_param;
      ev.param_two = p2;
      trk_phase = PH_DELTA;
      vlq_value = '0;
      vlq_len = '0;
      return ev;
   endfunction

   function automatic parse_status_type take_body_byte(input logic [7:0] b,
                                                       output mtp_result_type ev);
      vlq_status_type v;
      logic [7:0]     hi;
      ev = '0;
      case (trk_phase)
         PH_P1: begin
            first_param = b;
            hi = event_status & HI_NIBBLE;
            if (hi != STATUS_PROG && hi != STATUS_PRESS) begin
               trk_phase = PH_P2;
               return PARSE_NONE;
            end
            ev = channel_event(8'h00);
            return PARSE_EVENT;
         end
         PH_P2: begin
            ev = channel_event(b);
            return PARSE_EVENT;
         end
         PH_MTYPE: begin
            meta_type = b;
            vlq_value = '0;
            vlq_len = '0;
            trk_phase = PH_MLEN;
            return PARSE_NONE;
         end
         PH_SXLEN, PH_MLEN: begin
            v = take_vlq_byte(b);
            if (v == VLQ_LONG) return PARSE_ERROR;
            if (v == VLQ_MORE) return PARSE_NONE;
            if (trk_phase == PH_MLEN && meta_type == META_TEMPO && vlq_value == TEMPO_LENGTH) begin
               tempo_value = '0;
               tempo_len = '0;
               trk_phase = PH_TEMPO;
               return PARSE_NONE;
            end
            if (vlq_value != '0) begin
               bytes_to_skip = vlq_value;
               trk_phase = PH_SKIP;
               return PARSE_NONE;
            end
            ev = long_event(1'b0);
            return PARSE_EVENT;
         end
         PH_SKIP: begin
            bytes_to_skip = bytes_to_skip - 28'd1;
            if (bytes_to_skip != '0) return PARSE_NONE;
            ev = long_event(1'b0);
            return PARSE_EVENT;
         end
         PH_TEMPO: begin
            tempo_value = {tempo_value[15:0], b};
            if (tempo_len >= 2'd2) begin
               ev = long_event(1'b1);
               return PARSE_EVENT;
            end
            tempo_len = tempo_len + 2'd1;
            return PARSE_NONE;
         end
         default: return PARSE_ERROR;
      endcase
   endfunction

   // Advances the predicted parser by one item; returns 1 with the event it causes.
   function automatic logic parse_track_item(input logic op, input logic [7:0] b,
                                             input logic last, output mtp_result_type ev);
      parse_status_type st;
      vlq_status_type   v;
      ev = '0;
      if (op == OP_RESTART) begin
         clear_parser();
         return 1'b0;
      end
      if (parser_halted) return 1'b0;
      st = PARSE_NONE;
      case (trk_phase)
         PH_DELTA: begin
            v = take_vlq_byte(b);
            if (v == VLQ_LONG) begin
               st = PARSE_ERROR;
            end else if (v == VLQ_DONE) begin
               event_delta = vlq_value;
               vlq_value = '0;
               vlq_len = '0;
               trk_phase = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (b[7]) begin
               stored_status = b;
               if (!start_body(b)) st = PARSE_ERROR;
            end else if (!start_body(stored_status)) begin
               st = PARSE_ERROR;
            end else begin
               // running status: this byte already belongs to the body
               st = take_body_byte(b, ev);
            end
         end
         default: st = take_body_byte(b, ev);
      endcase
      if (st == PARSE_EVENT) begin
         if (last) parser_halted = 1'b1;
         return 1'b1;
      end
      if (st == PARSE_ERROR || last) begin
         ev = '0;
         ev.result_kind = KIND_ERROR;
         parser_halted = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [27:0] want, input logic [27:0] got);
      if (got !== want) report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
   endtask

   task automatic compare_event(input mtp_result_type want, input mtp_result_type got);
      check_field("result_kind", 28'(want.result_kind), 28'(got.result_kind));
      check_field("delta_ticks", want.delta_ticks, got.delta_ticks);
      check_field("status_class", 28'(want.status_class), 28'(got.status_class));
      check_field("channel", 28'(want.channel), 28'(got.channel));
      check_field("param_one", 28'(want.param_one), 28'(got.param_one));
      check_field("param_two", 28'(want.param_two), 28'(got.param_two));
      check_field("meta_kind", 28'(want.meta_kind), 28'(got.meta_kind));
      check_field("payload_length", want.payload_length, got.payload_length);
      check_field("tempo", 28'(want.tempo), 28'(got.tempo));
      check_field("tempo_valid", 28'(want.tempo_valid), 28'(got.tempo_valid));
      check_field("track_done", 28'(want.track_done), 28'(got.track_done));
   endtask

   always @(posedge clock) begin : result_tracker
      mtp_result_type ev;
      mtp_result_type got;
      logic           moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            if (req_op == OP_RESTART || !parser_halted) live_items++;
            if (parse_track_item(req_op, req_data_byte, req_last_byte, ev))
               pending_events.push_back(ev);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got.result_kind    = rsp_result_kind;
            got.delta_ticks    = rsp_delta_ticks;
            got.status_class   = rsp_status_class;
            got.channel        = rsp_channel;
            got.param_one      = rsp_param_one;
            got.param_two      = rsp_param_two;
            got.meta_kind      = rsp_meta_kind;
            got.payload_length = rsp_payload_length;
            got.tempo          = rsp_tempo;
            got.tempo_valid    = rsp_tempo_valid;
            got.track_done     = rsp_track_done;
            if (pending_events.size() == 0) begin
               report_mismatch("event item with nothing expected");
            end else begin
               compare_event(pending_events.pop_front(), got);
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL midi_track_event_parser_core");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   task automatic send_item(input logic op, input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sends the low n bytes of seq, most significant first
   task automatic send_bytes(input logic [63:0] seq, input int n, input logic last);
      for (int i = n - 1; i >= 0; i--) send_item(OP_BYTE, seq[8 * i +: 8], last && i == 0);
   endtask

   task automatic send_track(input logic last_at_end);
      foreach (track_bytes[i])
         send_item(OP_BYTE, track_bytes[i], last_at_end && i == track_bytes.size() - 1);
      track_bytes.delete();
   endtask

   // pad adds leading continuation bytes (0x80), never beyond four bytes
   task automatic put_vlq(input logic [27:0] v, input int pad);
      int n;
      n = 1;
      while (n < 4 && (v >> (7 * n)) != 0) n++;
      n = (n + pad > 4) ? 4 : n + pad;
      for (int i = n - 1; i >= 0; i--) track_bytes.push_back({i != 0, v[7 * i +: 7]});
   endtask

   function automatic logic [7:0] random_data();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   task automatic build_event();
      logic [7:0]  st;
      logic [7:0]  first;
      logic [27:0] dlt;
      logic [27:0] len;
      int          pick;
      int          pad;
      dlt = 28'($urandom) >> (7 * $urandom_range(0, 3));
      put_vlq(dlt, ($urandom_range(0, 7) == 0) ? 1 : 0);
      pick = $urandom_range(0, 9);
      pad = ($urandom_range(0, 7) == 0) ? 1 : 0;
      len = 28'($urandom_range(0, 4));
      if (pick < 5) begin
         st = 8'h80 + 8'($urandom_range(0, 8'h6F));
         first = random_data();
      end else if (pick < 7) begin
         st = (pick == 5) ? STATUS_SYSEX : STATUS_ESCAPE;
         first = (pad != 0) ? 8'h80 : {1'b0, len[6:0]};
      end else begin
         st = STATUS_META;
         first = ($urandom_range(0, 2) == 0) ? META_TEMPO : 8'($urandom_range(0, 255));
         if (first == META_TEMPO && $urandom_range(0, 3) != 0) len = TEMPO_LENGTH;
      end
      // a repeated status may be left out when the body opens with a data byte
      if (st != stream_status || first[7] || $urandom_range(0, 1) == 0) track_bytes.push_back(st);
      stream_status = st;
      if (pick < 5) begin
         track_bytes.push_back(first);
         if ((st & HI_NIBBLE) != STATUS_PROG && (st & HI_NIBBLE) != STATUS_PRESS)
            track_bytes.push_back(random_data());
      end else begin
         if (st == STATUS_META) track_bytes.push_back(first);
         put_vlq(len, pad);
         repeat (len) track_bytes.push_back(random_data());
      end
   endtask

   task automatic test_channel_events();
      send_item(OP_RESTART, 8'hFF, 1'b1);
      // all-ones 28-bit delta, then parameters with the top bit set
      send_bytes(64'hFF_FF_FF_7F_9F_FF_80, 7, 1'b0);
      send_bytes(64'h00_45_00, 3, 1'b0);
   endtask

   task automatic test_meta_events();
      send_bytes(64'h00_FF_51_03_FF_FF_FF, 7, 1'b0);
      // end of track under running meta status halts the parser
      send_bytes(64'h7F_2F_00, 3, 1'b0);
      send_item(OP_BYTE, 8'h12, 1'b0);
   endtask

   task automatic test_stream_end();
      send_item(OP_RESTART, 8'h00, 1'b0);
      send_bytes(64'h00_F7_00, 3, 1'b0);
      send_bytes(64'h00_D3_7F, 3, 1'b1);
      send_item(OP_BYTE, 8'h55, 1'b0);
      send_item(OP_RESTART, 8'h00, 1'b0);
      send_bytes(64'h00_F0_01, 3, 1'b1);
   endtask

   task automatic test_errors();
      send_item(OP_RESTART, 8'h00, 1'b0);
      send_bytes(64'h00_40, 2, 1'b0);
      send_item(OP_RESTART, 8'h00, 1'b0);
      send_bytes(64'h80_80_80_80, 4, 1'b0);
      send_item(OP_RESTART, 8'h00, 1'b0);
      send_bytes(64'h00_F4, 2, 1'b0);
   endtask

   task automatic test_random_tracks(input int target);
      int   start_count;
      int   cut;
      logic last;
      start_count = live_items;
      while (live_items - start_count < target) begin
         if ($urandom_range(0, 4) != 0) begin
            send_item(OP_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            stream_status = 8'h00;
         end
         repeat ($urandom_range(1, 6)) build_event();
         last = 1'b0;
         case ($urandom_range(0, 9))
            0, 1: begin
               put_vlq(28'($urandom_range(0, 127)), 0);
               track_bytes.push_back(STATUS_META);
               track_bytes.push_back(META_EOT);
               track_bytes.push_back(8'h00);
               stream_status = STATUS_META;
            end
            2, 3: last = 1'b1;
            4: begin
               cut = $urandom_range(0, track_bytes.size() - 1);
               while (track_bytes.size() > cut + 1) void'(track_bytes.pop_back());
               last = 1'b1;
            end
            5: track_bytes[$urandom_range(0, track_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            default: ;
         endcase
         send_track(last);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_BYTE;
      req_data_byte  = 8'h00;
      req_last_byte  = 1'b0;
      rsp_stall      = 1'b0;
      mismatches     = 0;
      live_items     = 0;
      idle_cycles    = 0;
      stream_status  = 8'h00;
      send_idle_pct  = 27;
      recv_stall_pct = 87;
      clear_parser();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_channel_events();
      test_meta_events();
      test_stream_end();
      test_errors();
      test_random_tracks(ITEMS_PER_MIX);
      send_idle_pct  = 87;
      recv_stall_pct = 27;
      test_random_tracks(ITEMS_PER_MIX);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_tracks(ITEMS_PER_MIX);

      @(negedge clock);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_events.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS midi_track_event_parser_core");
      end else begin
         $display("FAIL midi_track_event_parser_core");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/mtp_pkg.sv
design/mtp_front.sv
design/mtp_parser.sv
design/midi_track_event_parser_core.sv
bench/midi_track_event_parser_core_test.sv
